/* src/hpg_pkg.sv */
// Package: types, widths, register codes and the arctangent table for the marker pose block.
package hpg_pkg;

    localparam int CORNERS              = 4;
    localparam int NREGS                = 8;
    localparam int HOMOG_FRAC_BITS_DEF  = 32;
    localparam int H_W                  = 48;
    localparam int PIX_W                = 18;
    localparam int MUL_W                = H_W + PIX_W;
    localparam int PROD_W               = 68;
    localparam int NUM_W                = 88;
    localparam int DEN_W                = PROD_W + 1;
    localparam int CMP_W                = 112;
    localparam int Q_W                  = 41;
    localparam int PT_W                 = 42;
    localparam int CFG_IDX_W            = 4;
    localparam int CORDIC_STEPS         = 24;
    localparam int Z_W                  = 27;

    localparam logic [CFG_IDX_W-1:0] REG_H00 = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_H01 = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_H02 = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_H10 = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_H11 = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_H12 = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_H20 = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_H21 = 4'd7;

    typedef logic [NREGS-1:0][H_W-1:0] hset_t;

    typedef struct packed {
        logic [17:0] corner0_u;
        logic [17:0] corner0_v;
        logic [17:0] corner1_u;
        logic [17:0] corner1_v;
        logic [17:0] corner2_u;
        logic [17:0] corner2_v;
        logic [17:0] corner3_u;
        logic [17:0] corner3_v;
    } item_t;

    typedef struct packed {
        logic        pose_valid;
        logic [31:0] pose_x;
        logic [31:0] pose_y;
        logic [15:0] pose_yaw;
    } result_t;

    typedef struct packed {
        logic valid;
        logic w_zero;
    } lane_stat_t;

    function automatic logic signed [Z_W-1:0] atan_lut(input int i);
        logic signed [Z_W-1:0] r;
        case (i)
            0:       r = 27'sd4194304;
            1:       r = 27'sd2476042;
            2:       r = 27'sd1308273;
            3:       r = 27'sd664100;
            4:       r = 27'sd333339;
            5:       r = 27'sd166832;
            6:       r = 27'sd83436;
            7:       r = 27'sd41721;
            8:       r = 27'sd20861;
            9:       r = 27'sd10430;
            10:      r = 27'sd5215;
            11:      r = 27'sd2608;
            12:      r = 27'sd1304;
            13:      r = 27'sd652;
            14:      r = 27'sd326;
            15:      r = 27'sd163;
            16:      r = 27'sd81;
            17:      r = 27'sd41;
            18:      r = 27'sd20;
            19:      r = 27'sd10;
            20:      r = 27'sd5;
            21:      r = 27'sd3;
            22:      r = 27'sd1;
            23:      r = 27'sd1;
            default: r = 27'sd0;
        endcase
        return r;
    endfunction

endpackage

/* src/hpg_lane.sv */
// One corner lane: homography projection and pipelined restoring division to plane coordinates.
module hpg_lane #(
    parameter int HOMOG_FRAC_BITS = hpg_pkg::HOMOG_FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic signed [hpg_pkg::PIX_W-1:0]  u,
    input  logic signed [hpg_pkg::PIX_W-1:0]  v,
    input  hpg_pkg::hset_t                    h,
    output hpg_pkg::lane_stat_t               stat,
    output logic signed [hpg_pkg::PT_W-1:0]   px,
    output logic signed [hpg_pkg::PT_W-1:0]   py
);
    localparam int MW  = hpg_pkg::MUL_W;
    localparam int PW  = hpg_pkg::PROD_W;
    localparam int NW  = hpg_pkg::NUM_W;
    localparam int DW  = hpg_pkg::DEN_W;
    localparam int CW  = hpg_pkg::CMP_W;
    localparam int QW  = hpg_pkg::Q_W;
    localparam int TW  = hpg_pkg::PT_W;
    localparam logic signed [PW-1:0] W_ONE = PW'(1) << (HOMOG_FRAC_BITS + 4);
    localparam logic [QW-1:0] Q_LIM = QW'(1) << (QW - 1);

    // stage 1: products
    logic                 s1_valid_reg;
    logic signed [MW-1:0] pa_reg [0:5];
    logic signed [MW-1:0] pa_next [0:5];
    // stage 2: numerators and w
    logic                 s2_valid_reg;
    logic signed [PW-1:0] n0_reg, n1_reg, w_reg;
    logic signed [PW-1:0] n0_next, n1_next, w_next;
    // stage 3: magnitudes
    logic                 s3_valid_reg;
    logic [NW-1:0]        nx_reg, ny_reg, nx_next, ny_next;
    logic [DW-1:0]        d_reg, d_next;
    logic                 negx_reg, negy_reg, wz_reg;
    logic [PW-1:0]        an0, an1, adw;
    // division chain, index 0 holds the overflow check
    logic                 dv_valid_reg [0:QW];
    logic [NW-1:0]        rx_reg [0:QW];
    logic [NW-1:0]        ry_reg [0:QW];
    logic [NW-1:0]        rx_next [0:QW];
    logic [NW-1:0]        ry_next [0:QW];
    logic [QW-1:0]        qx_reg [0:QW];
    logic [QW-1:0]        qy_reg [0:QW];
    logic [QW-1:0]        qx_next [0:QW];
    logic [QW-1:0]        qy_next [0:QW];
    logic [DW-1:0]        dd_reg [0:QW];
    logic                 ox_reg [0:QW];
    logic                 oy_reg [0:QW];
    logic                 ox_next, oy_next;
    logic                 sx_reg [0:QW];
    logic                 sy_reg [0:QW];
    logic                 z_reg [0:QW];
    logic [CW-1:0]        lim;
    // output
    logic                 out_valid_reg;
    logic                 out_zero_reg;
    logic signed [TW-1:0] px_reg, py_reg, px_next, py_next;
    logic [QW-1:0]        mx, my;

    always_comb
    begin
        pa_next[0] = MW'($signed(h[0])) * MW'(u);
        pa_next[1] = MW'($signed(h[1])) * MW'(v);
        pa_next[2] = MW'($signed(h[3])) * MW'(u);
        pa_next[3] = MW'($signed(h[4])) * MW'(v);
        pa_next[4] = MW'($signed(h[6])) * MW'(u);
        pa_next[5] = MW'($signed(h[7])) * MW'(v);
        n0_next = PW'(pa_reg[0]) + PW'(pa_reg[1]) + (PW'($signed(h[2])) <<< 4);
        n1_next = PW'(pa_reg[2]) + PW'(pa_reg[3]) + (PW'($signed(h[5])) <<< 4);
        w_next  = PW'(pa_reg[4]) + PW'(pa_reg[5]) + W_ONE;
        an0 = n0_reg[PW-1] ? PW'(-n0_reg) : PW'(n0_reg);
        an1 = n1_reg[PW-1] ? PW'(-n1_reg) : PW'(n1_reg);
        adw = w_reg[PW-1] ? PW'(-w_reg) : PW'(w_reg);
        nx_next = (NW'(an0) << 17) + NW'(adw);
        ny_next = (NW'(an1) << 17) + NW'(adw);
        d_next  = {adw, 1'b0};
        lim     = (CW'(d_reg) << (QW - 1)) + CW'(d_reg);
        ox_next = CW'(nx_reg) >= lim;
        oy_next = CW'(ny_reg) >= lim;
        rx_next[0] = nx_reg;
        ry_next[0] = ny_reg;
        qx_next[0] = '0;
        qy_next[0] = '0;
        for (int j = 0; j < QW; j++)
        begin
            if (CW'(rx_reg[j]) >= (CW'(dd_reg[j]) << (QW - 1 - j)))
            begin
                rx_next[j+1] = NW'(CW'(rx_reg[j]) - (CW'(dd_reg[j]) << (QW - 1 - j)));
                qx_next[j+1] = {qx_reg[j][QW-2:0], 1'b1};
            end
            else
            begin
                rx_next[j+1] = rx_reg[j];
                qx_next[j+1] = {qx_reg[j][QW-2:0], 1'b0};
            end
            if (CW'(ry_reg[j]) >= (CW'(dd_reg[j]) << (QW - 1 - j)))
            begin
                ry_next[j+1] = NW'(CW'(ry_reg[j]) - (CW'(dd_reg[j]) << (QW - 1 - j)));
                qy_next[j+1] = {qy_reg[j][QW-2:0], 1'b1};
            end
            else
            begin
                ry_next[j+1] = ry_reg[j];
                qy_next[j+1] = {qy_reg[j][QW-2:0], 1'b0};
            end
        end
        mx = ox_reg[QW] ? Q_LIM : qx_reg[QW];
        my = oy_reg[QW] ? Q_LIM : qy_reg[QW];
        px_next = sx_reg[QW] ? -TW'(mx) : TW'(mx);
        py_next = sy_reg[QW] ? -TW'(my) : TW'(my);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int j = 0; j <= QW; j++)
            begin
                dv_valid_reg[j] <= 1'b0;
            end
        end
        else
        begin
            s1_valid_reg    <= in_valid;
            s2_valid_reg    <= s1_valid_reg;
            s3_valid_reg    <= s2_valid_reg;
            dv_valid_reg[0] <= s3_valid_reg;
            for (int j = 0; j < QW; j++)
            begin
                dv_valid_reg[j+1] <= dv_valid_reg[j];
            end
            out_valid_reg <= dv_valid_reg[QW];
        end
    end

    always_ff @(posedge clk)
    begin
        pa_reg   <= pa_next;
        n0_reg   <= n0_next;
        n1_reg   <= n1_next;
        w_reg    <= w_next;
        nx_reg   <= nx_next;
        ny_reg   <= ny_next;
        d_reg    <= d_next;
        negx_reg <= n0_reg[PW-1] ^ w_reg[PW-1];
        negy_reg <= n1_reg[PW-1] ^ w_reg[PW-1];
        wz_reg   <= (w_reg == '0);
        dd_reg[0] <= d_reg;
        ox_reg[0] <= ox_next;
        oy_reg[0] <= oy_next;
        sx_reg[0] <= negx_reg;
        sy_reg[0] <= negy_reg;
        z_reg[0]  <= wz_reg;
        rx_reg[0] <= rx_next[0];
        ry_reg[0] <= ry_next[0];
        qx_reg[0] <= qx_next[0];
        qy_reg[0] <= qy_next[0];
        for (int j = 0; j < QW; j++)
        begin
            rx_reg[j+1] <= rx_next[j+1];
            ry_reg[j+1] <= ry_next[j+1];
            qx_reg[j+1] <= qx_next[j+1];
            qy_reg[j+1] <= qy_next[j+1];
            dd_reg[j+1] <= dd_reg[j];
            ox_reg[j+1] <= ox_reg[j];
            oy_reg[j+1] <= oy_reg[j];
            sx_reg[j+1] <= sx_reg[j];
            sy_reg[j+1] <= sy_reg[j];
            z_reg[j+1]  <= z_reg[j];
        end
        px_reg       <= px_next;
        py_reg       <= py_next;
        out_zero_reg <= z_reg[QW];
    end

    assign stat.valid  = out_valid_reg;
    assign stat.w_zero = out_zero_reg;
    assign px = px_reg;
    assign py = py_reg;

endmodule

/* src/hpg_merge.sv */
// Merge stage: centroid, cross/dot sums, normalization and CORDIC yaw.
module hpg_merge (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    input  logic                                   in_bad,
    input  logic signed [hpg_pkg::PT_W-1:0]        px [0:hpg_pkg::CORNERS-1],
    input  logic signed [hpg_pkg::PT_W-1:0]        py [0:hpg_pkg::CORNERS-1],
    output logic                                   out_valid,
    output hpg_pkg::result_t                       out_result
);
    localparam int TW = hpg_pkg::PT_W;
    localparam int SW = TW + 2;
    localparam int XW = TW + 3;
    localparam int NVW = 47;
    localparam int MGW = 46;
    localparam int NS = 6;
    localparam int VW = 49;
    localparam int ZW = hpg_pkg::Z_W;
    localparam int CS = hpg_pkg::CORDIC_STEPS;
    localparam int LAT = NS + 1 + CS;

    typedef struct packed {
        logic        bad;
        logic        zero;
        logic [31:0] mx;
        logic [31:0] my;
    } side_t;

    logic                 m1_valid_reg, m1_bad_reg;
    logic signed [SW-1:0] sx_reg, sy_reg, sx_next, sy_next;
    logic signed [XW-1:0] scr_reg, sdt_reg, scr_next, sdt_next;

    logic                  v_reg [0:LAT];
    side_t                 sd_reg [0:LAT];
    side_t                 sd_next;
    logic signed [SW:0]    tx, ty;
    logic signed [SW-2:0]  cx, cy;

    logic signed [NVW-1:0] nx_reg [0:NS];
    logic signed [NVW-1:0] ny_reg [0:NS];
    logic [MGW-1:0]        mg_reg [0:NS];
    logic signed [NVW-1:0] nx_next [0:NS];
    logic signed [NVW-1:0] ny_next [0:NS];
    logic [MGW-1:0]        mg_next [0:NS];
    logic [MGW-1:0]        ax, ay;

    logic signed [VW-1:0]  xc_reg [0:CS];
    logic signed [VW-1:0]  yc_reg [0:CS];
    logic signed [ZW-1:0]  zc_reg [0:CS];
    logic signed [VW-1:0]  xc_next [0:CS];
    logic signed [VW-1:0]  yc_next [0:CS];
    logic signed [ZW-1:0]  zc_next [0:CS];
    logic signed [VW-1:0]  xs, ys, x0, y0;

    logic                  o_valid_reg;
    hpg_pkg::result_t      o_reg, o_next;
    logic [ZW:0]           ysum;

    always_comb
    begin
        sx_next  = SW'(px[0]) + SW'(px[1]) + SW'(px[2]) + SW'(px[3]);
        sy_next  = SW'(py[0]) + SW'(py[1]) + SW'(py[2]) + SW'(py[3]);
        scr_next = -XW'(py[0]) + XW'(py[1]) + XW'(py[2]) - XW'(py[3])
                   - XW'(px[0]) - XW'(px[1]) + XW'(px[2]) + XW'(px[3]);
        sdt_next = -XW'(px[0]) + XW'(px[1]) + XW'(px[2]) - XW'(px[3])
                   + XW'(py[0]) + XW'(py[1]) - XW'(py[2]) - XW'(py[3]);

        tx = (SW+1)'(sx_reg) + (SW+1)'(2);
        ty = (SW+1)'(sy_reg) + (SW+1)'(2);
        cx = (SW-1)'(tx >>> 2);
        cy = (SW-1)'(ty >>> 2);
        sd_next.bad  = m1_bad_reg;
        sd_next.zero = (scr_reg == '0) && (sdt_reg == '0);
        if (cx > (SW-1)'(32'sh7FFFFFFF))
            sd_next.mx = 32'h7FFFFFFF;
        else if (cx < -(SW-1)'(33'sh080000000))
            sd_next.mx = 32'h80000000;
        else
            sd_next.mx = cx[31:0];
        if (cy > (SW-1)'(32'sh7FFFFFFF))
            sd_next.my = 32'h7FFFFFFF;
        else if (cy < -(SW-1)'(33'sh080000000))
            sd_next.my = 32'h80000000;
        else
            sd_next.my = cy[31:0];

        ax = sdt_reg[XW-1] ? MGW'(-sdt_reg) : MGW'(sdt_reg);
        ay = scr_reg[XW-1] ? MGW'(-scr_reg) : MGW'(scr_reg);
        nx_next[0] = NVW'(sdt_reg);
        ny_next[0] = NVW'(scr_reg);
        mg_next[0] = (ax > ay) ? ax : ay;
        for (int j = 0; j < NS; j++)
        begin
            if (mg_reg[j] < (MGW'(1) << (45 - (32 >> j))))
            begin
                nx_next[j+1] = nx_reg[j] <<< (32 >> j);
                ny_next[j+1] = ny_reg[j] <<< (32 >> j);
                mg_next[j+1] = mg_reg[j] << (32 >> j);
            end
            else
            begin
                nx_next[j+1] = nx_reg[j];
                ny_next[j+1] = ny_reg[j];
                mg_next[j+1] = mg_reg[j];
            end
        end

        x0 = VW'(nx_reg[NS]);
        y0 = VW'(ny_reg[NS]);
        if (x0 < 0)
        begin
            if (y0 >= 0)
            begin
                xc_next[0] = y0;
                yc_next[0] = -x0;
                zc_next[0] = ZW'(8388608);
            end
            else
            begin
                xc_next[0] = -y0;
                yc_next[0] = x0;
                zc_next[0] = -ZW'(8388608);
            end
        end
        else
        begin
            xc_next[0] = x0;
            yc_next[0] = y0;
            zc_next[0] = '0;
        end
        for (int i = 0; i < CS; i++)
        begin
            xs = xc_reg[i] >>> i;
            ys = yc_reg[i] >>> i;
            if (yc_reg[i] >= 0)
            begin
                xc_next[i+1] = xc_reg[i] + ys;
                yc_next[i+1] = yc_reg[i] - xs;
                zc_next[i+1] = zc_reg[i] + hpg_pkg::atan_lut(i);
            end
            else
            begin
                xc_next[i+1] = xc_reg[i] - ys;
                yc_next[i+1] = yc_reg[i] + xs;
                zc_next[i+1] = zc_reg[i] - hpg_pkg::atan_lut(i);
            end
        end

        ysum = (ZW+1)'(zc_reg[CS]) + (ZW+1)'(33554688);
        if (sd_reg[LAT].bad)
        begin
            o_next = '0;
        end
        else
        begin
            o_next.pose_valid = 1'b1;
            o_next.pose_x     = sd_reg[LAT].mx;
            o_next.pose_y     = sd_reg[LAT].my;
            o_next.pose_yaw   = sd_reg[LAT].zero ? 16'd0 : ysum[24:9];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_valid_reg <= 1'b0;
            o_valid_reg  <= 1'b0;
            for (int j = 0; j <= LAT; j++)
            begin
                v_reg[j] <= 1'b0;
            end
        end
        else
        begin
            m1_valid_reg <= in_valid;
            v_reg[0]     <= m1_valid_reg;
            for (int j = 0; j < LAT; j++)
            begin
                v_reg[j+1] <= v_reg[j];
            end
            o_valid_reg <= v_reg[LAT];
        end
    end

    always_ff @(posedge clk)
    begin
        m1_bad_reg <= in_bad;
        sx_reg     <= sx_next;
        sy_reg     <= sy_next;
        scr_reg    <= scr_next;
        sdt_reg    <= sdt_next;
        sd_reg[0]  <= sd_next;
        for (int j = 0; j < LAT; j++)
        begin
            sd_reg[j+1] <= sd_reg[j];
        end
        for (int j = 0; j <= NS; j++)
        begin
            nx_reg[j] <= nx_next[j];
            ny_reg[j] <= ny_next[j];
            mg_reg[j] <= mg_next[j];
        end
        for (int i = 0; i <= CS; i++)
        begin
            xc_reg[i] <= xc_next[i];
            yc_reg[i] <= yc_next[i];
            zc_reg[i] <= zc_next[i];
        end
        o_reg <= o_next;
    end

    assign out_valid  = o_valid_reg;
    assign out_result = o_reg;

endmodule

/* src/marker_pose_from_ground_homography.sv */
// Top level: homography register file, four corner lanes and the pose merge stage.
// Fully pipelined: one item is taken every clock cycle and busy never rises. Each result
// appears on result with result_valid for one cycle; the pipeline depth is dominated by
// the 41-stage restoring divider in each corner lane and the 24-stage CORDIC in the
// merge stage. The receiver cannot stall the block, so results must be captured when
// result_valid is high. Write homography registers only while no item is in flight;
// cfg_ready is always high and writes to indexes above 7 are dropped.
module marker_pose_from_ground_homography #(
    parameter int HOMOG_FRAC_BITS = hpg_pkg::HOMOG_FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  hpg_pkg::item_t                    item,
    output logic                              result_valid,
    output hpg_pkg::result_t                  result,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [hpg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [hpg_pkg::H_W-1:0]           cfg_data
);
    localparam logic [hpg_pkg::H_W-1:0] H_ONE = hpg_pkg::H_W'(1) << HOMOG_FRAC_BITS;
    localparam logic [hpg_pkg::H_W-1:0] H_ZERO = '0;
    localparam hpg_pkg::hset_t H_RESET = {H_ZERO, H_ZERO, H_ZERO, H_ONE,
                                          H_ZERO, H_ZERO, H_ZERO, H_ONE};

    hpg_pkg::hset_t       h_reg;
    hpg_pkg::lane_stat_t  stat [0:hpg_pkg::CORNERS-1];
    logic signed [hpg_pkg::PT_W-1:0]  px [0:hpg_pkg::CORNERS-1];
    logic signed [hpg_pkg::PT_W-1:0]  py [0:hpg_pkg::CORNERS-1];
    logic signed [hpg_pkg::PIX_W-1:0] cu [0:hpg_pkg::CORNERS-1];
    logic signed [hpg_pkg::PIX_W-1:0] cv [0:hpg_pkg::CORNERS-1];
    logic                 accept;
    logic                 any_zero;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start & ~busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_reg <= H_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                hpg_pkg::REG_H00: h_reg[0] <= cfg_data;
                hpg_pkg::REG_H01: h_reg[1] <= cfg_data;
                hpg_pkg::REG_H02: h_reg[2] <= cfg_data;
                hpg_pkg::REG_H10: h_reg[3] <= cfg_data;
                hpg_pkg::REG_H11: h_reg[4] <= cfg_data;
                hpg_pkg::REG_H12: h_reg[5] <= cfg_data;
                hpg_pkg::REG_H20: h_reg[6] <= cfg_data;
                hpg_pkg::REG_H21: h_reg[7] <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cu[0] = $signed(item.corner0_u);
    assign cv[0] = $signed(item.corner0_v);
    assign cu[1] = $signed(item.corner1_u);
    assign cv[1] = $signed(item.corner1_v);
    assign cu[2] = $signed(item.corner2_u);
    assign cv[2] = $signed(item.corner2_v);
    assign cu[3] = $signed(item.corner3_u);
    assign cv[3] = $signed(item.corner3_v);

    for (genvar k = 0; k < hpg_pkg::CORNERS; k++)
    begin : g_lane
        hpg_lane #(
            .HOMOG_FRAC_BITS (HOMOG_FRAC_BITS)
        ) u_lane (
            .clk      (clk),
            .rst_n    (rst_n),
            .in_valid (accept),
            .u        (cu[k]),
            .v        (cv[k]),
            .h        (h_reg),
            .stat     (stat[k]),
            .px       (px[k]),
            .py       (py[k])
        );
    end

    assign any_zero = stat[0].w_zero | stat[1].w_zero | stat[2].w_zero | stat[3].w_zero;

    hpg_merge u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (stat[0].valid),
        .in_bad     (any_zero),
        .px         (px),
        .py         (py),
        .out_valid  (result_valid),
        .out_result (result)
    );

endmodule
